### sv/pps_pkg.sv
// Shared types and constants for the preemptive priority scheduler.
package pps_pkg;

  localparam int MAX_PROCS_DEF = 64;
  localparam int TIME_W        = 24;
  localparam int ARR_W         = 16;
  localparam int BURST_W       = 16;
  localparam int PRIO_W        = 8;
  localparam int PID_W         = 7;

  localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};

  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_TICK = 1'b1;

  typedef struct packed {
    logic [ARR_W-1:0]   arrival;
    logic [BURST_W-1:0] burst;
    logic [BURST_W-1:0] remaining;
    logic [PRIO_W-1:0]  prio;
  } pps_entry_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DRAIN,
    S_WB
  } pps_state_t;

endpackage

### sv/preemptive_priority_scheduler_top.sv
// Top level of the preemptive priority scheduler: control sequencer and result registers.
//
// A load request (cmd 0) gives no result; it is ignored when the table is full
// or the burst is zero. A tick request (cmd 1) reads the process table once per
// loaded slot through its single read port, then writes the chosen entry back:
// busy stays high through the scan, drain and write-back states after the
// request (only write-back with nothing loaded). The result is shown for
// exactly one cycle with done high, in the cycle after the write-back; the
// receiver cannot stall it and a new request may be taken in that same cycle.
// turnaround and waiting are zero unless finished is set.
module preemptive_priority_scheduler_top
  import pps_pkg::*;
#(
  parameter int MAX_PROCS = MAX_PROCS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic               cmd,
  input  logic [ARR_W-1:0]   arrival_time,
  input  logic [BURST_W-1:0] burst_time,
  input  logic [PRIO_W-1:0]  prio_level,
  output logic               done,
  output logic               ran,
  output logic [PID_W-1:0]   process_id,
  output logic               finished,
  output logic [TIME_W-1:0]  turnaround,
  output logic [TIME_W-1:0]  waiting,
  output logic               all_done
);

  localparam int IW = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
  localparam int CW = $clog2(MAX_PROCS + 1);

  pps_state_t state, state_next;

  logic [CW-1:0]     loaded_count;
  logic [CW-1:0]     done_count;
  logic [TIME_W-1:0] now_time;
  logic [IW-1:0]     idx;
  logic [IW-1:0]     rd_idx;
  logic              rd_valid;

  logic       accept;
  logic       load_ok;
  logic       last_read;
  logic       rd_en;
  logic       wr_en;
  logic [IW-1:0] wr_addr;
  pps_entry_t wr_data;
  pps_entry_t rd_data;
  pps_entry_t load_entry;

  logic       found;
  logic [IW-1:0] best_idx;
  pps_entry_t best_entry;

  logic [BURST_W-1:0] rem_dec;
  logic               fin;
  logic [TIME_W-1:0]  now_next;
  logic [TIME_W-1:0]  tat;
  logic [TIME_W-1:0]  wt;
  logic [CW-1:0]      pid_full;
  logic [CW-1:0]      done_count_next;

  assign busy      = (state != S_IDLE);
  assign accept    = start && !busy;
  assign load_ok   = (burst_time != '0) && (loaded_count < CW'(MAX_PROCS));
  assign last_read = ((CW'(idx) + CW'(1)) == loaded_count);

  always_comb begin
    load_entry.arrival   = arrival_time;
    load_entry.burst     = burst_time;
    load_entry.remaining = burst_time;
    load_entry.prio      = prio_level;
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept && (cmd == CMD_TICK)) begin
          state_next = (loaded_count == '0) ? S_WB : S_SCAN;
        end
      end
      S_SCAN: begin
        if (last_read) state_next = S_DRAIN;
      end
      S_DRAIN: state_next = S_WB;
      S_WB:    state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    rd_en   = 1'b0;
    wr_en   = 1'b0;
    wr_addr = loaded_count[IW-1:0];
    wr_data = load_entry;
    unique case (state)
      S_IDLE: begin
        wr_en = accept && (cmd == CMD_LOAD) && load_ok;
      end
      S_SCAN: begin
        rd_en = 1'b1;
      end
      S_DRAIN: ;
      S_WB: begin
        wr_en             = found;
        wr_addr           = best_idx;
        wr_data           = best_entry;
        wr_data.remaining = rem_dec;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idx      <= '0;
      rd_valid <= 1'b0;
    end else begin
      rd_valid <= rd_en;
      if (state == S_IDLE) begin
        idx <= '0;
      end else if (rd_en) begin
        idx <= idx + IW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    rd_idx <= idx;
  end

  pps_mem #(
    .DEPTH(MAX_PROCS)
  ) u_mem (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(wr_addr),
    .wr_data(wr_data),
    .rd_en  (rd_en),
    .rd_addr(idx),
    .rd_data(rd_data)
  );

  pps_scan #(
    .MAX_PROCS(MAX_PROCS)
  ) u_scan (
    .clk       (clk),
    .rst       (rst),
    .clear     (state == S_IDLE),
    .in_valid  (rd_valid),
    .in_idx    (rd_idx),
    .in_entry  (rd_data),
    .now_time  (now_time),
    .found     (found),
    .best_idx  (best_idx),
    .best_entry(best_entry)
  );

  // write-back arithmetic
  always_comb begin
    rem_dec         = best_entry.remaining - BURST_W'(1);
    fin             = found && (rem_dec == '0);
    now_next        = (now_time < TIME_MAX) ? now_time + TIME_W'(1) : now_time;
    tat             = now_next - TIME_W'(best_entry.arrival);
    wt              = (tat >= TIME_W'(best_entry.burst)) ?
                      tat - TIME_W'(best_entry.burst) : '0;
    pid_full        = CW'(best_idx) + CW'(1);
    done_count_next = done_count + CW'(fin);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      loaded_count <= '0;
      done_count   <= '0;
      now_time     <= '0;
      done         <= 1'b0;
    end else begin
      done <= (state == S_WB);
      if (wr_en && (state == S_IDLE)) begin
        loaded_count <= loaded_count + CW'(1);
      end
      if (state == S_WB) begin
        now_time   <= now_next;
        done_count <= done_count_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_WB) begin
      ran        <= found;
      process_id <= found ? PID_W'(pid_full) : '0;
      finished   <= fin;
      turnaround <= fin ? tat : '0;
      waiting    <= fin ? wt : '0;
      all_done   <= (done_count_next == loaded_count);
    end
  end

endmodule

### sv/pps_mem.sv
// Process table: one write port, one registered read port.
module pps_mem
  import pps_pkg::*;
#(
  parameter int DEPTH = MAX_PROCS_DEF,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  pps_entry_t    wr_data,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output pps_entry_t    rd_data
);

  pps_entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

### sv/pps_scan.sv
// Best-candidate tracker fed one table entry per cycle during a tick scan.
module pps_scan
  import pps_pkg::*;
#(
  parameter int MAX_PROCS = MAX_PROCS_DEF,
  localparam int IW = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              clear,
  input  logic              in_valid,
  input  logic [IW-1:0]     in_idx,
  input  pps_entry_t        in_entry,
  input  logic [TIME_W-1:0] now_time,
  output logic              found,
  output logic [IW-1:0]     best_idx,
  output pps_entry_t        best_entry
);

  logic eligible;
  logic better;

  always_comb begin
    eligible = (TIME_W'(in_entry.arrival) <= now_time) && (in_entry.remaining != '0);
    better   = !found || (in_entry.prio < best_entry.prio) ||
               ((in_entry.prio == best_entry.prio) &&
                (in_entry.arrival < best_entry.arrival));
  end

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      found <= 1'b0;
    end else if (in_valid && eligible && better) begin
      found <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && eligible && better) begin
      best_idx   <= in_idx;
      best_entry <= in_entry;
    end
  end

endmodule

### test/preemptive_priority_scheduler_top_tb.sv
// Self-checking testbench for the preemptive priority scheduler top level.
module preemptive_priority_scheduler_top_tb;
  import pps_pkg::*;

  localparam int IDLE_LIMIT    = 1000;
  localparam int SETTLE_CYCLES = MAX_PROCS_DEF + 8;
  localparam int RANDOM_ITEMS  = 1450;
  localparam int RANDOM_SLOTS  = MAX_PROCS_DEF - 3;

  typedef struct {
    logic              ran;
    logic [PID_W-1:0]  pid;
    logic              fin;
    logic [TIME_W-1:0] tat;
    logic [TIME_W-1:0] wt;
    logic              all_done;
  } tick_outcome_t;

  logic               clk;
  logic               rst = 1'b1;
  logic               start = 1'b0;
  logic               busy;
  logic               cmd = CMD_LOAD;
  logic [ARR_W-1:0]   arrival_time = '0;
  logic [BURST_W-1:0] burst_time = '0;
  logic [PRIO_W-1:0]  prio_level = '0;
  logic               done;
  logic               ran;
  logic [PID_W-1:0]   process_id;
  logic               finished;
  logic [TIME_W-1:0]  turnaround;
  logic [TIME_W-1:0]  waiting;
  logic               all_done;

  preemptive_priority_scheduler_top #(.MAX_PROCS(MAX_PROCS_DEF)) dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .cmd(cmd),
    .arrival_time(arrival_time), .burst_time(burst_time), .prio_level(prio_level),
    .done(done), .ran(ran), .process_id(process_id), .finished(finished),
    .turnaround(turnaround), .waiting(waiting), .all_done(all_done)
  );

  logic [ARR_W-1:0]   proc_arr[MAX_PROCS_DEF];
  logic [BURST_W-1:0] proc_burst[MAX_PROCS_DEF];
  logic [BURST_W-1:0] proc_rem[MAX_PROCS_DEF];
  logic [PRIO_W-1:0]  proc_prio[MAX_PROCS_DEF];
  int unsigned        n_loaded = 0;
  int unsigned        n_done = 0;
  logic [TIME_W-1:0]  now_tick = '0;

  tick_outcome_t tick_outcomes[$];
  tick_outcome_t due;
  int errors = 0;
  int idle_cycles = 0;
  int items_sent = 0;
  bit steady = 1'b0;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // scheduler state update
  task automatic admit_process(input logic [ARR_W-1:0] at, input logic [BURST_W-1:0] bt,
                               input logic [PRIO_W-1:0] pr);
    if (bt != 0 && n_loaded < MAX_PROCS_DEF) begin
      proc_arr[n_loaded]   = at;
      proc_burst[n_loaded] = bt;
      proc_rem[n_loaded]   = bt;
      proc_prio[n_loaded]  = pr;
      n_loaded++;
      items_sent++;
    end
  endtask

  task automatic run_tick;
    int best;
    bit found;
    tick_outcome_t r;
    best = 0;
    found = 1'b0;
    r = '{default: '0};
    for (int i = 0; i < n_loaded; i++) begin
      if ({8'd0, proc_arr[i]} <= now_tick && proc_rem[i] != 0) begin
        if (!found || proc_prio[i] < proc_prio[best] ||
            (proc_prio[i] == proc_prio[best] && proc_arr[i] < proc_arr[best])) begin
          best = i;
          found = 1'b1;
        end
      end
    end
    if (now_tick != TIME_MAX) now_tick++;
    if (found) begin
      proc_rem[best]--;
      r.ran = 1'b1;
      r.pid = PID_W'(best + 1);
      if (proc_rem[best] == 0) begin
        r.fin = 1'b1;
        n_done++;
        r.tat = now_tick - {8'd0, proc_arr[best]};
        r.wt  = (r.tat >= {8'd0, proc_burst[best]}) ? r.tat - {8'd0, proc_burst[best]} : '0;
      end
    end
    r.all_done = (n_done == n_loaded);
    tick_outcomes.push_back(r);
    items_sent++;
  endtask

  task automatic send_request(input logic c, input logic [ARR_W-1:0] at,
                              input logic [BURST_W-1:0] bt, input logic [PRIO_W-1:0] pr);
    int gap;
    gap = steady ? 0 : $urandom_range(0, 12);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start        <= 1'b1;
    cmd          <= c;
    arrival_time <= at;
    burst_time   <= bt;
    prio_level   <= pr;
    do @(posedge clk); while (busy);
    if (c == CMD_LOAD) admit_process(at, bt, pr);
    else run_tick;
  endtask

  task automatic load(input logic [ARR_W-1:0] at, input logic [BURST_W-1:0] bt,
                      input logic [PRIO_W-1:0] pr);
    send_request(CMD_LOAD, at, bt, pr);
  endtask

  task automatic tick;
    send_request(CMD_TICK, ARR_W'($urandom), BURST_W'($urandom), PRIO_W'($urandom));
  endtask

  task automatic drain_results;
    start <= 1'b0;
    do @(posedge clk); while (tick_outcomes.size() != 0);
  endtask

  task automatic load_random;
    int lo;
    logic [PRIO_W-1:0] pr;
    lo = (now_tick > 50) ? int'(now_tick) - 50 : 0;
    pr = $urandom_range(0, 1) ? PRIO_W'($urandom_range(0, 3)) : PRIO_W'($urandom);
    case ($urandom_range(0, 3))
      0: load(ARR_W'(now_tick), BURST_W'($urandom_range(1, 12)), pr);
      1: load(ARR_W'(now_tick + $urandom_range(20, 200)), BURST_W'($urandom_range(1, 6)), pr);
      default: load(ARR_W'(lo + $urandom_range(0, 80)), BURST_W'($urandom_range(1, 12)), pr);
    endcase
  endtask

  task automatic test_idle_start;
    repeat (3) tick;
    load(16'hFFFF, 16'd0, 8'hFF);
    load(16'd0, 16'd0, 8'd0);
    tick;
    drain_results;
  endtask

  task automatic test_priority_order;
    // preemption by a later urgent arrival, arrival tie-break, slot tie-break, extremes
    load(16'd0, 16'd3, 8'd5);
    load(16'd2, 16'd1, 8'd5);
    load(16'd1, 16'd1, 8'd5);
    load(16'd5, 16'd1, 8'd0);
    load(16'd0, 16'd1, 8'd255);
    load(16'd0, 16'd1, 8'd255);
    repeat (10) tick;
    drain_results;
  endtask

  task automatic test_random_workload;
    int n;
    n = 0;
    while (items_sent < RANDOM_ITEMS) begin
      if (n % 120 == 0) steady = ($urandom_range(0, 3) == 0);
      if (n == 700) drain_results;
      if (n_loaded < RANDOM_SLOTS && $urandom_range(0, 24) == 0) begin
        repeat ($urandom_range(1, 3)) if (n_loaded < RANDOM_SLOTS) load_random;
      end else if ($urandom_range(0, 39) == 0) begin
        load(ARR_W'($urandom), 16'd0, PRIO_W'($urandom));
      end else begin
        tick;
      end
      n++;
    end
    steady = 1'b0;
    drain_results;
  endtask

  task automatic test_full_table;
    while (n_loaded < RANDOM_SLOTS) load(ARR_W'(now_tick), BURST_W'($urandom_range(1, 4)),
                                         PRIO_W'($urandom));
    load(16'hFFFF, 16'hFFFF, 8'd0);
    load(16'd0, 16'hFFFF, 8'hFF);
    load(16'd0, 16'd2, 8'd0);
    repeat (3) load(ARR_W'($urandom), BURST_W'($urandom_range(1, 65535)), PRIO_W'($urandom));
    repeat (20) tick;
    drain_results;
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    test_idle_start;
    test_priority_order;
    test_random_workload;
    test_full_table;
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (errors == 0 && tick_outcomes.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  task automatic report_mismatch(input string what);
    $display("MISMATCH @%0t: %s", $time, what);
    errors++;
  endtask

  task automatic check_field(input string name, input logic [TIME_W-1:0] got,
                             input logic [TIME_W-1:0] want);
    if (got !== want) report_mismatch($sformatf("%s got %0d want %0d", name, got, want));
  endtask

  always @(posedge clk) begin
    if (!rst && done) begin
      if (tick_outcomes.size() == 0) begin
        report_mismatch("result with no tick request pending");
      end else begin
        due = tick_outcomes.pop_front();
        check_field("ran", TIME_W'(ran), TIME_W'(due.ran));
        check_field("process_id", TIME_W'(process_id), TIME_W'(due.pid));
        check_field("finished", TIME_W'(finished), TIME_W'(due.fin));
        check_field("turnaround", turnaround, due.tat);
        check_field("waiting", waiting, due.wt);
        check_field("all_done", TIME_W'(all_done), TIME_W'(due.all_done));
      end
    end
  end

  always @(posedge clk) begin
    if (rst || done || (start && !busy)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule

### preemptive_priority_scheduler_top.f
sv/pps_pkg.sv
sv/pps_mem.sv
sv/pps_scan.sv
sv/preemptive_priority_scheduler_top.sv
test/preemptive_priority_scheduler_top_tb.sv
